### rtl/core/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants for the priority eviction table: the input and
// result words, the per-slot table entry and the operation codes.
// ----------------------------------------------------------------------------
package pet_pkg;

  // Default table depth and reset value of the never-evict threshold
  localparam int         NUM_SLOTS_DEF   = 16;
  localparam logic [7:0] NEVER_EVICT_RST = 8'hFF;

  // Operation codes carried in the func field
  typedef enum logic [2:0] {
    FN_REGISTER = 3'd0,
    FN_LOADED   = 3'd1,
    FN_UNLOADED = 3'd2,
    FN_SET_IDLE = 3'd3,
    FN_SET_PRI  = 3'd4,
    FN_VICTIM   = 3'd5,
    FN_PREEMPT  = 3'd6,
    FN_READ_PRI = 3'd7
  } pet_func_t;

  // Input word
  typedef struct packed {
    pet_func_t   func;
    logic [3:0]  slot;
    logic [7:0]  priority_req;
    logic [15:0] budget_mib;
    logic        idle_flag;
  } pet_in_t;

  // Result word
  typedef struct packed {
    logic        found;
    logic [3:0]  slot_out;
    logic [7:0]  priority_out;
    logic [15:0] budget_out;
    logic        changed;
  } pet_out_t;

  // One table entry as kept in the slot memory
  typedef struct packed {
    logic        loaded;
    logic        idle;
    logic [7:0]  pri;
    logic [15:0] budget;
  } pet_entry_t;

endpackage

### rtl/core/priority_eviction_table.sv
// ----------------------------------------------------------------------------
// priority_eviction_table
// Table of NUM_SLOTS slots with priority-based eviction victim and
// preemption target search.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation word; out_valid/out_ready/
//   out_data return exactly one result word per operation, in order.
//   cfg_valid/cfg_ready/cfg_data write the never-evict threshold; write it
//   only while no operation is outstanding. cfg_ready is always high.
//   Register, update and read operations do one read-modify-write of the
//   slot memory: the slot is read as the word is accepted, any write-back
//   and the result come from S_MOD, and S_HOLD loads the output register.
//   Victim and preemption searches read one slot per cycle from the slot
//   memory port in S_SCAN, fold in the last slot in S_LAST, and S_HOLD
//   then loads the output register.
//   One operation is in flight at a time; in_ready returns in the same cycle
//   that the result appears in the output register, so the next word is
//   taken while a result still waits there.
//   Reset clears all slot registrations and sets the threshold to 255.
//   When out_ready is low the result holds in the output register and the
//   following operation waits, finished, until that register frees up.
// ----------------------------------------------------------------------------
module priority_eviction_table #(
  parameter int NUM_SLOTS = pet_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pet_pkg::pet_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pet_pkg::pet_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import pet_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);

  logic [7:0]    never_evict_r;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  pet_entry_t    mem_wr_entry;
  logic          mem_rd_valid;
  pet_entry_t    mem_rd_entry;

  // Never-evict threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      never_evict_r <= NEVER_EVICT_RST;
    end else if (cfg_valid) begin
      never_evict_r <= cfg_data;
    end
  end

  // Sequencer
  pet_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .never_evict  (never_evict_r),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_entry (mem_wr_entry),
    .mem_rd_valid (mem_rd_valid),
    .mem_rd_entry (mem_rd_entry)
  );

  // Slot storage
  pet_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_entry (mem_wr_entry),
    .rd_valid (mem_rd_valid),
    .rd_entry (mem_rd_entry)
  );

endmodule

### rtl/core/pet_slot_mem.sv
// ----------------------------------------------------------------------------
// pet_slot_mem
// Slot table storage: one synchronous memory of entries with a registered
// read port, plus a row of valid flops that reset clears.
// ----------------------------------------------------------------------------
module pet_slot_mem #(
  parameter int NUM_SLOTS = pet_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
  input  pet_pkg::pet_entry_t          wr_entry,
  output logic                         rd_valid,
  output pet_pkg::pet_entry_t          rd_entry
);
  import pet_pkg::*;

  pet_entry_t           mem_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic                 rd_valid_r;
  pet_entry_t           rd_entry_r;

  // Entry array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  // Valid bits: any write marks the slot registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_entry = rd_entry_r;

endmodule

### rtl/core/pet_ctrl.sv
// ----------------------------------------------------------------------------
// pet_ctrl
// Operation sequencer: read-modify-write of one slot for the update and read
// operations, a one-slot-per-cycle scan for the victim and preemption
// searches, and the output register of the result channel.
// ----------------------------------------------------------------------------
module pet_ctrl #(
  parameter int NUM_SLOTS = pet_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pet_pkg::pet_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pet_pkg::pet_out_t            out_data,
  input  logic [7:0]                   never_evict,
  output logic                         mem_rd_en,
  output logic [$clog2(NUM_SLOTS)-1:0] mem_rd_addr,
  output logic                         mem_wr_en,
  output logic [$clog2(NUM_SLOTS)-1:0] mem_wr_addr,
  output pet_pkg::pet_entry_t          mem_wr_entry,
  input  logic                         mem_rd_valid,
  input  pet_pkg::pet_entry_t          mem_rd_entry
);
  import pet_pkg::*;

  localparam int         AW         = $clog2(NUM_SLOTS);
  localparam logic [8:0] SLOT_LIMIT = 9'(NUM_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_LAST,
    S_HOLD
  } state_t;

  state_t          state_r, state_nxt;
  pet_in_t         item_r, item_nxt;
  logic            inside_r, inside_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]   chk_idx_r, chk_idx_nxt;
  logic            best_found_r, best_found_nxt;
  logic [AW-1:0]   best_idx_r, best_idx_nxt;
  logic [7:0]      best_pri_r, best_pri_nxt;
  logic [15:0]     best_bud_r, best_bud_nxt;
  pet_out_t        res_r, res_nxt;
  pet_out_t        out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            in_inside;
  logic            is_search;
  logic            cand;
  logic            better;
  logic            slot_ok;
  pet_entry_t      upd;

  assign in_inside = ({5'd0, in_data.slot} < SLOT_LIMIT);
  assign is_search = (in_data.func == FN_VICTIM) || (in_data.func == FN_PREEMPT);

  // Scan compare: eligibility of the entry just read, then ranking
  always_comb begin
    cand = mem_rd_valid && mem_rd_entry.loaded && mem_rd_entry.idle &&
           (mem_rd_entry.pri < never_evict);
    if (item_r.func == FN_PREEMPT) begin
      cand = cand && (mem_rd_entry.pri < item_r.priority_req) &&
             (mem_rd_entry.budget >= item_r.budget_mib);
    end
    better = !best_found_r || (mem_rd_entry.pri < best_pri_r) ||
             ((mem_rd_entry.pri == best_pri_r) && (mem_rd_entry.budget > best_bud_r));
  end

  // Next state, memory requests and result word
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    inside_nxt     = inside_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_pri_nxt   = best_pri_r;
    best_bud_nxt   = best_bud_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = cnt_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = AW'(item_r.slot);
    slot_ok        = inside_r && mem_rd_valid;
    upd            = mem_rd_entry;
    in_ready       = (state_r == S_IDLE);

    // fold the entry read last cycle into the running best
    if (chk_vld_r && cand && better) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = chk_idx_r;
      best_pri_nxt   = mem_rd_entry.pri;
      best_bud_nxt   = mem_rd_entry.budget;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          inside_nxt = in_inside;
          if (is_search) begin
            cnt_nxt        = '0;
            best_found_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end else begin
            mem_rd_en   = in_inside;
            mem_rd_addr = AW'(in_data.slot);
            state_nxt   = S_MOD;
          end
        end
      end

      S_MOD: begin
        res_nxt          = '0;
        res_nxt.slot_out = item_r.slot;
        if (item_r.func == FN_REGISTER) begin
          if (inside_r) begin
            upd.loaded           = 1'b0;
            upd.idle             = 1'b1;
            upd.pri              = item_r.priority_req;
            upd.budget           = item_r.budget_mib;
            mem_wr_en            = 1'b1;
            res_nxt.found        = 1'b1;
            res_nxt.priority_out = item_r.priority_req;
            res_nxt.budget_out   = item_r.budget_mib;
          end
        end else if (slot_ok) begin
          unique case (item_r.func)
            FN_LOADED:   upd.loaded = 1'b1;
            FN_UNLOADED: upd.loaded = 1'b0;
            FN_SET_IDLE: upd.idle   = item_r.idle_flag;
            FN_SET_PRI: begin
              upd.pri         = item_r.priority_req;
              res_nxt.changed = (mem_rd_entry.pri != item_r.priority_req);
            end
            default: ;
          endcase
          mem_wr_en            = (item_r.func != FN_READ_PRI);
          res_nxt.found        = 1'b1;
          res_nxt.priority_out = upd.pri;
          res_nxt.budget_out   = upd.budget;
        end
        state_nxt = S_HOLD;
      end

      S_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_r;
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = cnt_r;
        cnt_nxt     = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end
      end

      S_LAST: begin
        // last entry is folded in above; take the updated best
        res_nxt       = '0;
        res_nxt.found = best_found_nxt;
        if (best_found_nxt) begin
          res_nxt.slot_out     = 4'(best_idx_nxt);
          res_nxt.priority_out = best_pri_nxt;
          res_nxt.budget_out   = best_bud_nxt;
        end
        state_nxt = S_HOLD;
      end

      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    mem_wr_entry = upd;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      chk_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      best_found_r <= best_found_nxt;
    end
    item_r     <= item_nxt;
    inside_r   <= inside_nxt;
    cnt_r      <= cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    best_bud_r <= best_bud_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/pet_checker.sv
// ----------------------------------------------------------------------------
// pet_port_checker
// Port-level checks for the priority eviction table, bound to the top level.
// ----------------------------------------------------------------------------
module pet_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pet_pkg::pet_out_t out_data
);
  import pet_pkg::*;

  // No result word survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // One operation at a time: input closes after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word dropped or changed");

  // A miss carries no priority, budget or change flag
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.priority_out == 8'd0 && out_data.budget_out == 16'd0 &&
       !out_data.changed))
    else $error("miss result with nonzero fields");

endmodule

bind priority_eviction_table pet_port_checker u_pet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
